// ===== rtl/array_priority_queue_macros.svh =====
// Assertion macros used by the priority queue sequencer.
`ifndef ARRAY_PRIORITY_QUEUE_MACROS_SVH
`define ARRAY_PRIORITY_QUEUE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define APQ_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define APQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/apq_pkg.sv =====
// Package with transaction types and codes for the priority queue.
package apq_pkg;

    localparam int VAL_W = 32;
    localparam int PRI_W = 16;
    localparam int OCC_W = 7;
    localparam int ST_W  = 2;

    // Request opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic                    opcode;
        logic signed [VAL_W-1:0] item_value;
        logic signed [PRI_W-1:0] item_priority;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic signed [VAL_W-1:0] removed_value;
        logic [OCC_W-1:0]        occupancy;
    } t_rsp;

    // One stored entry
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic signed [PRI_W-1:0] prio;
    } t_entry;

    // Controller status seen by the top level
    typedef struct packed {
        logic idle;
        logic res_valid;
        t_rsp res;
    } t_ctl_out;

endpackage

// ===== rtl/apq_mem.sv =====
// Entry store: one write port, one read port, registered read data.
module apq_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  apq_pkg::t_entry i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output apq_pkg::t_entry o_rd_data
);

    apq_pkg::t_entry mem [0:DEPTH-1];
    apq_pkg::t_entry r_rd_data;

    // Write entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read entry into the registered read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/apq_ctl.sv =====
// Sequencer: append on insert, scan then shift down on remove.
`include "array_priority_queue_macros.svh"

module apq_ctl #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int CW    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  apq_pkg::t_req     i_req,
    input  logic              i_res_free,
    output apq_pkg::t_ctl_out o_ctl,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output apq_pkg::t_entry   o_wr_data,
    output logic              o_rd_en,
    output logic [AW-1:0]     o_rd_addr,
    input  apq_pkg::t_entry   i_rd_data
);

    localparam int OW = apq_pkg::OCC_W;
    localparam int VW = apq_pkg::VAL_W;
    localparam int PW = apq_pkg::PRI_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_state;

    t_state                 r_state;
    logic [CW-1:0]          r_cnt;
    logic [CW-1:0]          r_ptr;
    logic [CW-1:0]          r_dq;
    logic [CW-1:0]          r_bidx;
    logic signed [PW-1:0]   r_bpri;
    logic signed [VW-1:0]   r_bval;
    logic                   r_first;
    logic [apq_pkg::ST_W-1:0] r_status;
    logic signed [VW-1:0]   r_rm_val;

    logic                   take;
    logic [CW-1:0]          n_bidx;
    logic signed [PW-1:0]   n_bpri;
    logic signed [VW-1:0]   n_bval;
    logic [CW-1:0]          dq_inc;
    logic [CW-1:0]          dq_dec;
    logic [CW-1:0]          bidx_inc;
    logic                   fin_under;
    logic                   fin_over;
    logic                   dq_in_range;

    // Track the best entry; strict compare keeps the earliest on ties
    always_comb begin
        take     = r_first || (i_rd_data.prio > r_bpri);
        n_bidx   = take ? r_dq : r_bidx;
        n_bpri   = take ? i_rd_data.prio : r_bpri;
        n_bval   = take ? i_rd_data.value : r_bval;
        dq_inc   = r_dq + ONE_C;
        dq_dec   = r_dq - ONE_C;
        bidx_inc = n_bidx + ONE_C;
    end

    // Drive memory ports; the sequencer keeps read and write on distinct entries
    always_comb begin
        o_wr_en   = 1'b0;
        o_wr_addr = r_cnt[AW-1:0];
        o_wr_data = '{value: i_req.item_value, prio: i_req.item_priority};
        o_rd_en   = 1'b0;
        o_rd_addr = r_ptr[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_req.opcode == apq_pkg::OP_INSERT) begin
                        o_wr_en = (r_cnt != DEPTH_C);
                    end else begin
                        o_rd_en   = (r_cnt != '0);
                        o_rd_addr = '0;
                    end
                end
            end
            S_SCAN: begin
                if (r_ptr != r_cnt) begin
                    o_rd_en = 1'b1;
                end else if (bidx_inc != r_cnt) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = bidx_inc[AW-1:0];
                end
            end
            S_SHIFT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = dq_dec[AW-1:0];
                o_wr_data = i_rd_data;
                o_rd_en   = (dq_inc != r_cnt);
                o_rd_addr = dq_inc[AW-1:0];
            end
            S_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // Advance the sequencer and hold the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_status <= apq_pkg::ST_OK;
                        r_rm_val <= '0;
                        if (i_req.opcode == apq_pkg::OP_INSERT) begin
                            if (r_cnt == DEPTH_C) begin
                                r_status <= apq_pkg::ST_OVERFLOW;
                            end else begin
                                r_cnt <= r_cnt + ONE_C;
                            end
                            r_state <= S_FINISH;
                        end else if (r_cnt == '0) begin
                            r_status <= apq_pkg::ST_UNDERFLOW;
                            r_state  <= S_FINISH;
                        end else begin
                            r_ptr   <= ONE_C;
                            r_dq    <= '0;
                            r_first <= 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_first <= 1'b0;
                    r_bidx  <= n_bidx;
                    r_bpri  <= n_bpri;
                    r_bval  <= n_bval;
                    if (r_ptr != r_cnt) begin
                        r_dq  <= r_ptr;
                        r_ptr <= r_ptr + ONE_C;
                    end else begin
                        r_rm_val <= n_bval;
                        if (bidx_inc == r_cnt) begin
                            r_cnt   <= r_cnt - ONE_C;
                            r_state <= S_FINISH;
                        end else begin
                            r_dq    <= bidx_inc;
                            r_state <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    if (dq_inc != r_cnt) begin
                        r_dq <= dq_inc;
                    end else begin
                        r_cnt   <= r_cnt - ONE_C;
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (i_res_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ctl.idle              = (r_state == S_IDLE);
    assign o_ctl.res_valid         = (r_state == S_FINISH);
    assign o_ctl.res.status        = r_status;
    assign o_ctl.res.removed_value = r_rm_val;
    assign o_ctl.res.occupancy     = OW'(r_cnt);

    // Conditions watched by the assertions
    assign fin_under   = (r_state == S_FINISH) && (r_status == apq_pkg::ST_UNDERFLOW);
    assign fin_over    = (r_state == S_FINISH) && (r_status == apq_pkg::ST_OVERFLOW);
    assign dq_in_range = (r_dq != '0) && (r_dq < r_cnt);

    `APQ_ASSERT_ALWAYS(a_cnt_range, r_cnt <= DEPTH_C, "fill count beyond depth")
    `APQ_ASSERT_IMPLY(a_underflow_empty, fin_under, r_cnt == '0, "underflow while not empty")
    `APQ_ASSERT_IMPLY(a_overflow_full, fin_over, r_cnt == DEPTH_C, "overflow while not full")
    `APQ_ASSERT_IMPLY(a_shift_range, r_state == S_SHIFT, dq_in_range, "shift source out of range")

endmodule

// ===== rtl/array_priority_queue.sv =====
// Priority queue over an unsorted entry store: top level with output register.
//
// Request channel (i_in_valid / o_in_stall / i_in_data): a transaction is an
// insert (value and priority) or a remove of the highest priority entry.
// Result channel (o_out_valid / i_out_stall / o_out_data): exactly one result
// transaction per request, with status, removed value and occupancy.
// Insert: the entry is written in the accept cycle; the sequencer then
// waits in its finish state until the output register is free, hands the
// result to it and returns to idle, where a new request can be taken.
// Remove: the scan reads the held entries' priorities one per cycle from
// the store's single read port, the shift state moves the entries after the
// best one down one place, then the finish state hands the result to the
// output register. Overflow and underflow go straight to the finish state.
// o_in_stall is high while a request is in progress. A finished result waits
// in the output register while i_out_stall is high; the next request may
// still be taken, and it stalls only at its own completion.
// Synchronous reset empties the queue and drops any pending result.
module array_priority_queue #(
    parameter int DEPTH = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  apq_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output apq_pkg::t_rsp o_out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    apq_pkg::t_ctl_out ctl;
    apq_pkg::t_entry   wr_data;
    apq_pkg::t_entry   rd_data;
    logic              wr_en;
    logic              rd_en;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic              start;
    logic              res_free;

    logic              r_out_valid;
    apq_pkg::t_rsp     r_out_data;

    // Take a request only while the sequencer is idle
    assign o_in_stall = !ctl.idle;
    assign start      = i_in_valid && ctl.idle;
    assign res_free   = !r_out_valid || !i_out_stall;

    apq_ctl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (i_in_data),
        .i_res_free (res_free),
        .o_ctl      (ctl),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data)
    );

    apq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Load a finished result, drop it once the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.res_valid && res_free) begin
            r_out_valid <= 1'b1;
            r_out_data  <= ctl.res;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
